### rtl/irs_pkg.sv
// Shared constants, types and fixed-point helpers for the independent row selector.
package irs_pkg;

    // Array sizes
    localparam int MAX_ELEMENTS   = 32;
    localparam int MAX_COMPONENTS = 16;
    localparam int EL_W           = $clog2(MAX_ELEMENTS);
    localparam int CP_W           = $clog2(MAX_COMPONENTS);
    localparam int COEF_DEPTH     = MAX_ELEMENTS * MAX_COMPONENTS;
    localparam int BASIS_DEPTH    = MAX_COMPONENTS * MAX_COMPONENTS;

    // Field and register widths
    localparam int CMD_W   = 2;
    localparam int COEF_W  = 16;
    localparam int POS_W   = 4;
    localparam int EC_W    = 6;
    localparam int CC_W    = 5;
    localparam int THR_W   = 33;
    localparam int Q_W     = 64;
    localparam int FRAC_W  = 32;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;

    // Register reset values
    localparam logic [EC_W-1:0]  EC_RESET  = EC_W'(32);
    localparam logic [CC_W-1:0]  CC_RESET  = CC_W'(16);
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(4295);

    // Saturation limits
    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    // Iteration counts of the arithmetic units
    localparam int MUL_STEPS = 4;
    localparam int DIV_STEPS = Q_W + FRAC_W;

    // Input commands
    typedef enum logic [CMD_W-1:0] {
        CMD_WR_COEF   = 2'd0,
        CMD_WR_ACTIVE = 2'd1,
        CMD_RUN       = 2'd2,
        CMD_NOP       = 2'd3
    } t_cmd;

    // Register indexes (paddr[4:3])
    localparam logic [1:0] REG_ELEMENT_COUNT   = 2'd0;
    localparam logic [1:0] REG_COMPONENT_COUNT = 2'd1;
    localparam logic [1:0] REG_NORM_THRESHOLD  = 2'd2;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_FIND,
        S_LD_RD,
        S_LD_WR,
        S_DOT_RD,
        S_DOT_ST,
        S_DOT_WT,
        S_DIV_ST,
        S_DIV_WT,
        S_SUB_RD,
        S_SUB_ST,
        S_SUB_WT,
        S_NRM_ST,
        S_NRM_WT,
        S_DECIDE,
        S_SWAP,
        S_EMIT,
        S_ERR
    } t_state;

    // Requests to the arithmetic units
    typedef struct packed {
        logic                  start;
        logic signed [Q_W-1:0] a;
        logic signed [Q_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                  start;
        logic signed [Q_W-1:0] num;
        logic signed [Q_W-1:0] den;
    } t_div_req;

    // Magnitude of a signed Q32.32 value
    function automatic logic [Q_W-1:0] mag_of(input logic signed [Q_W-1:0] a);
        return a[Q_W-1] ? Q_W'(-a) : Q_W'(a);
    endfunction

    // Apply sign to a magnitude, saturating to the signed range
    function automatic logic signed [Q_W-1:0] sat_mag(input logic neg,
                                                      input logic [Q_W-1:0] mag,
                                                      input logic ovf);
        logic big;
        big = ovf || mag[Q_W-1];
        if (!neg) begin
            return big ? Q_MAX : signed'(mag);
        end
        return big ? Q_MIN : -signed'(mag);
    endfunction

    function automatic logic signed [Q_W-1:0] sat_add(input logic signed [Q_W-1:0] a,
                                                      input logic signed [Q_W-1:0] b);
        logic signed [Q_W-1:0] s;
        s = a + b;
        if ((a[Q_W-1] == b[Q_W-1]) && (s[Q_W-1] != a[Q_W-1])) begin
            return a[Q_W-1] ? Q_MIN : Q_MAX;
        end
        return s;
    endfunction

    function automatic logic signed [Q_W-1:0] sat_sub(input logic signed [Q_W-1:0] a,
                                                      input logic signed [Q_W-1:0] b);
        logic signed [Q_W-1:0] s;
        s = a - b;
        if ((a[Q_W-1] != b[Q_W-1]) && (s[Q_W-1] != a[Q_W-1])) begin
            return a[Q_W-1] ? Q_MIN : Q_MAX;
        end
        return s;
    endfunction

endpackage

### rtl/irs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module irs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/irs_mul.sv
// Multi-cycle Q32.32 multiplier: four 32x32 partial products, truncate and saturate.
module irs_mul
    import irs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_mul_req              i_req,
    output logic                  o_done,
    output logic signed [Q_W-1:0] o_p
);

    logic [Q_W-1:0]          r_ua;
    logic [Q_W-1:0]          r_ub;
    logic                    r_neg;
    logic [2*Q_W-1:0]        r_acc;
    logic [2:0]              r_step;
    logic                    r_busy;
    logic                    r_done;
    logic signed [Q_W-1:0]   r_p;

    logic [FRAC_W-1:0]       a_half;
    logic [FRAC_W-1:0]       b_half;
    logic [2*FRAC_W-1:0]     pp;
    logic [2*Q_W-1:0]        pp_sh;

    // Partial product for the current step: bit 0 picks the half of a, bit 1 of b
    always_comb begin
        a_half = r_step[0] ? r_ua[Q_W-1:FRAC_W] : r_ua[FRAC_W-1:0];
        b_half = r_step[1] ? r_ub[Q_W-1:FRAC_W] : r_ub[FRAC_W-1:0];
        pp     = a_half * b_half;
        case (r_step[1:0])
            2'd0:    pp_sh = (2*Q_W)'(pp);
            2'd3:    pp_sh = (2*Q_W)'(pp) << (2*FRAC_W);
            default: pp_sh = (2*Q_W)'(pp) << FRAC_W;
        endcase
    end

    // Step sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_ua   <= mag_of(i_req.a);
                r_ub   <= mag_of(i_req.b);
                r_neg  <= i_req.a[Q_W-1] ^ i_req.b[Q_W-1];
                r_acc  <= '0;
                r_step <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_step < 3'(MUL_STEPS)) begin
                    r_acc  <= r_acc + pp_sh;
                    r_step <= r_step + 3'd1;
                end else begin
                    // keep bits 95:32, anything above means overflow
                    r_p    <= sat_mag(r_neg, r_acc[Q_W+FRAC_W-1:FRAC_W],
                                      |r_acc[2*Q_W-1:Q_W+FRAC_W]);
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

### rtl/irs_div.sv
// Radix-2 restoring Q32.32 divider, one quotient bit per cycle, truncating and saturating.
module irs_div
    import irs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_div_req              i_req,
    output logic                  o_done,
    output logic signed [Q_W-1:0] o_q
);

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic [DIV_STEPS-1:0]  r_num;
    logic [DIV_STEPS-1:0]  r_quo;
    logic [Q_W-1:0]        r_rem;
    logic [Q_W-1:0]        r_ud;
    logic                  r_neg;
    logic                  r_zero;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic signed [Q_W-1:0] r_q;

    logic [Q_W-1:0]        shifted;
    logic                  ge;

    // Remainder stays below the divisor (< 2^63), so one shift fits 64 bits
    always_comb begin
        shifted = {r_rem[Q_W-2:0], r_num[DIV_STEPS-1]};
        ge      = shifted >= r_ud;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_num  <= {mag_of(i_req.num), {FRAC_W{1'b0}}};
                r_ud   <= Q_W'(i_req.den);
                r_neg  <= i_req.num[Q_W-1];
                // non-positive divisor gives zero
                r_zero <= i_req.den[Q_W-1] || (i_req.den == '0);
                r_rem  <= '0;
                r_quo  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt < CNT_W'(DIV_STEPS)) begin
                    r_rem <= ge ? (shifted - r_ud) : shifted;
                    r_quo <= {r_quo[DIV_STEPS-2:0], ge};
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt + CNT_W'(1);
                end else begin
                    r_q    <= r_zero ? '0 : sat_mag(r_neg, r_quo[Q_W-1:0],
                                                    |r_quo[DIV_STEPS-1:Q_W]);
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

### rtl/independent_row_selector_core.sv
// Independent row selector: coefficient store, Gram-Schmidt sequencer and result port.
// Writes may follow back to back; a run holds the input off until done.
// A run scans the order slots for a candidate and loads its row; per basis row it
// computes the projections and the subtraction, then the norm.
// Results then leave one per cycle from the output register while the receiver is ready.
// Reset (synchronous, active low) restores registers, clears active flags and the output.
module independent_row_selector_core
    import irs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic [EL_W-1:0]          i_element,
    input  logic [CP_W-1:0]          i_component,
    input  logic signed [COEF_W-1:0] i_coefficient,
    input  logic                     i_active,
    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [POS_W-1:0]         o_position,
    output logic [EL_W-1:0]          o_chosen_element,
    output logic                     o_last,
    output logic                     o_error,
    // configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    t_state r_state;
    t_state n_state;

    // configuration
    logic [EC_W-1:0]  r_ec;
    logic [CC_W-1:0]  r_cc;
    logic [THR_W-1:0] r_thr;

    // small per-element state
    logic             r_active [MAX_ELEMENTS];
    logic             r_tried  [MAX_ELEMENTS];
    logic [EL_W-1:0]  r_order  [MAX_ELEMENTS];

    // working row, projections and basis norms
    logic signed [Q_W-1:0] r_cand  [MAX_COMPONENTS];
    logic signed [Q_W-1:0] r_proj  [MAX_COMPONENTS];
    logic signed [Q_W-1:0] r_norms [MAX_COMPONENTS];
    logic signed [Q_W-1:0] r_dot;
    logic signed [Q_W-1:0] r_norm;

    // loop counters
    logic [EC_W-1:0] r_p;
    logic [CC_W-1:0] r_jr;
    logic [CP_W-1:0] r_i;
    logic [CP_W-1:0] r_j;
    logic [EL_W-1:0] r_k;
    logic [EL_W-1:0] r_el;

    // output register
    logic             r_out_valid;
    logic [POS_W-1:0] r_pos;
    logic [EL_W-1:0]  r_chosen;
    logic             r_last;
    logic             r_err;

    // derived control
    logic             in_acc;
    logic             cfg_wr;
    logic             out_free;
    logic             counts_bad;
    logic [EL_W-1:0]  ord_addr;
    logic [EL_W-1:0]  ord_q;
    logic signed [Q_W-1:0] cand_q;
    logic             find_end;
    logic             find_hit;
    logic             i_last;
    logic             j_last;
    logic             jr_last;
    logic             accept;

    // memories and units
    logic [COEF_W-1:0]     coef_q;
    logic [Q_W-1:0]        basis_q;
    t_mul_req              mul_req;
    t_div_req              div_req;
    logic                  mul_done;
    logic signed [Q_W-1:0] mul_p;
    logic                  div_done;
    logic signed [Q_W-1:0] div_q;

    // Handshake and loop conditions
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        in_acc     = i_in_valid && o_in_ready;
        cfg_wr     = psel && penable && pwrite;
        out_free   = !r_out_valid || i_out_ready;
        counts_bad = (r_ec == '0) || (r_ec > EC_W'(MAX_ELEMENTS)) ||
                     (r_cc == '0) || (r_cc > CC_W'(MAX_COMPONENTS));
        case (r_state)
            S_SWAP:  ord_addr = EL_W'(r_jr);
            S_EMIT:  ord_addr = EL_W'(r_i);
            default: ord_addr = r_p[EL_W-1:0];
        endcase
        ord_q    = r_order[ord_addr];
        cand_q   = r_cand[r_i];
        find_end = r_p >= r_ec;
        find_hit = r_active[ord_q] && !r_tried[ord_q];
        i_last   = (CC_W'(r_i) + CC_W'(1)) == r_cc;
        j_last   = (CC_W'(r_j) + CC_W'(1)) == r_jr;
        jr_last  = (r_jr + CC_W'(1)) == r_cc;
        accept   = r_norm > $signed({{(Q_W-THR_W){1'b0}}, r_thr});
    end

    // Arithmetic unit requests
    always_comb begin
        mul_req.start = (r_state == S_DOT_ST) || (r_state == S_SUB_ST) ||
                        (r_state == S_NRM_ST);
        mul_req.a     = (r_state == S_SUB_ST) ? r_proj[r_j] : cand_q;
        mul_req.b     = (r_state == S_NRM_ST) ? cand_q : signed'(basis_q);
        div_req.start = (r_state == S_DIV_ST);
        div_req.num   = r_dot;
        div_req.den   = r_norms[r_j];
    end

    // Coefficient store: written by input transactions, read row by row during a run
    irs_ram #(
        .WIDTH (COEF_W),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && (i_cmd == CMD_WR_COEF)),
        .i_waddr ({i_element, i_component}),
        .i_wdata (i_coefficient),
        .i_raddr ({r_el, r_i}),
        .o_rdata (coef_q)
    );

    // Basis rows: row jr written during the norm pass, rows below jr read
    irs_ram #(
        .WIDTH (Q_W),
        .DEPTH (BASIS_DEPTH)
    ) u_basis_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_NRM_ST),
        .i_waddr ({r_jr[CP_W-1:0], r_i}),
        .i_wdata (Q_W'(cand_q)),
        .i_raddr ({r_j, r_i}),
        .o_rdata (basis_q)
    );

    irs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    irs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_cmd == CMD_RUN)) begin
                    n_state = counts_bad ? S_ERR : S_FIND;
                end
            end
            S_FIND: begin
                if (find_end) begin
                    n_state = S_ERR;
                end else if (find_hit) begin
                    n_state = S_LD_RD;
                end
            end
            S_LD_RD: n_state = S_LD_WR;
            S_LD_WR: begin
                if (i_last) begin
                    n_state = (r_jr == '0) ? S_NRM_ST : S_DOT_RD;
                end else begin
                    n_state = S_LD_RD;
                end
            end
            S_DOT_RD: n_state = S_DOT_ST;
            S_DOT_ST: n_state = S_DOT_WT;
            S_DOT_WT: begin
                if (mul_done) begin
                    n_state = i_last ? S_DIV_ST : S_DOT_RD;
                end
            end
            S_DIV_ST: n_state = S_DIV_WT;
            S_DIV_WT: begin
                if (div_done) begin
                    n_state = j_last ? S_SUB_RD : S_DOT_RD;
                end
            end
            S_SUB_RD: n_state = S_SUB_ST;
            S_SUB_ST: n_state = S_SUB_WT;
            S_SUB_WT: begin
                if (mul_done) begin
                    n_state = (i_last && j_last) ? S_NRM_ST : S_SUB_RD;
                end
            end
            S_NRM_ST: n_state = S_NRM_WT;
            S_NRM_WT: begin
                if (mul_done) begin
                    n_state = i_last ? S_DECIDE : S_NRM_ST;
                end
            end
            S_DECIDE: n_state = accept ? S_SWAP : S_FIND;
            S_SWAP:   n_state = jr_last ? S_EMIT : S_FIND;
            S_EMIT: begin
                if (out_free && i_last) begin
                    n_state = S_IDLE;
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ec  <= EC_RESET;
            r_cc  <= CC_RESET;
            r_thr <= THR_RESET;
        end else if (cfg_wr) begin
            case (paddr[PADDR_W-1:3])
                REG_ELEMENT_COUNT:   r_ec  <= pwdata[EC_W-1:0];
                REG_COMPONENT_COUNT: r_cc  <= pwdata[CC_W-1:0];
                REG_NORM_THRESHOLD:  r_thr <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Configuration read back
    always_comb begin
        case (paddr[PADDR_W-1:3])
            REG_ELEMENT_COUNT:   prdata = PDATA_W'(r_ec);
            REG_COMPONENT_COUNT: prdata = PDATA_W'(r_cc);
            REG_NORM_THRESHOLD:  prdata = PDATA_W'(r_thr);
            default:             prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Per-element flags and order map
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < MAX_ELEMENTS; e++) begin
                r_active[e] <= 1'b0;
                r_tried[e]  <= 1'b0;
                r_order[e]  <= EL_W'(e);
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_cmd == CMD_WR_ACTIVE)) begin
                        r_active[i_element] <= i_active;
                    end
                    // each run starts from the identity order, nothing tried
                    if (in_acc && (i_cmd == CMD_RUN) && !counts_bad) begin
                        for (int e = 0; e < MAX_ELEMENTS; e++) begin
                            r_tried[e] <= 1'b0;
                            r_order[e] <= EL_W'(e);
                        end
                    end
                end
                S_FIND: begin
                    if (!find_end && find_hit) begin
                        r_tried[ord_q] <= 1'b1;
                    end
                end
                S_SWAP: begin
                    // candidate already in place needs no move
                    if (r_k != EL_W'(r_jr)) begin
                        r_order[r_k] <= ord_q;
                    end
                    r_order[EL_W'(r_jr)] <= r_el;
                end
                default: ;
            endcase
        end
    end

    // Sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p  <= '0;
            r_jr <= '0;
            r_i  <= '0;
            r_j  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_cmd == CMD_RUN)) begin
                        r_p  <= '0;
                        r_jr <= '0;
                        r_i  <= '0;
                    end
                end
                S_FIND: begin
                    if (!find_end) begin
                        if (find_hit) begin
                            r_k  <= r_p[EL_W-1:0];
                            r_el <= ord_q;
                            r_i  <= '0;
                        end else begin
                            r_p <= r_p + EC_W'(1);
                        end
                    end
                end
                // coefficient enters as integer * 2^32
                S_LD_WR: begin
                    r_cand[r_i] <= {{(Q_W-COEF_W-FRAC_W){coef_q[COEF_W-1]}}, coef_q,
                                    {FRAC_W{1'b0}}};
                    if (i_last) begin
                        r_i    <= '0;
                        r_j    <= '0;
                        r_dot  <= '0;
                        r_norm <= '0;
                    end else begin
                        r_i <= r_i + CP_W'(1);
                    end
                end
                S_DOT_WT: begin
                    if (mul_done) begin
                        r_dot <= sat_add(r_dot, mul_p);
                        r_i   <= i_last ? '0 : r_i + CP_W'(1);
                    end
                end
                S_DIV_WT: begin
                    if (div_done) begin
                        r_proj[r_j] <= div_q;
                        r_dot       <= '0;
                        r_j         <= j_last ? '0 : r_j + CP_W'(1);
                    end
                end
                S_SUB_WT: begin
                    if (mul_done) begin
                        r_cand[r_i] <= sat_sub(cand_q, mul_p);
                        if (i_last) begin
                            r_i <= '0;
                            r_j <= j_last ? '0 : r_j + CP_W'(1);
                        end else begin
                            r_i <= r_i + CP_W'(1);
                        end
                    end
                end
                S_NRM_WT: begin
                    if (mul_done) begin
                        r_norm <= sat_add(r_norm, mul_p);
                        r_i    <= i_last ? '0 : r_i + CP_W'(1);
                    end
                end
                S_DECIDE: begin
                    r_norms[r_jr[CP_W-1:0]] <= r_norm;
                    // rejected: rescan from this position
                    if (!accept) begin
                        r_p <= EC_W'(r_jr);
                    end
                end
                S_SWAP: begin
                    r_jr <= r_jr + CC_W'(1);
                    r_p  <= EC_W'(r_jr) + EC_W'(1);
                    r_i  <= '0;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_i <= r_i + CP_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
                r_pos       <= POS_W'(r_i);
                r_chosen    <= ord_q;
                r_last      <= i_last;
                r_err       <= 1'b0;
            end else if ((r_state == S_ERR) && out_free) begin
                r_out_valid <= 1'b1;
                r_pos       <= POS_W'(r_jr);
                r_chosen    <= '0;
                r_last      <= 1'b1;
                r_err       <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_position       = r_pos;
    assign o_chosen_element = r_chosen;
    assign o_last           = r_last;
    assign o_error          = r_err;

endmodule

### sim/tb_independent_row_selector_core.sv
// Self-checking testbench for the independent row selector core.
`timescale 1ns / 1ps

module tb_independent_row_selector_core
    import irs_pkg::*;
();

    localparam int     IDLE_LIMIT = 600000;
    localparam longint Q_ONE      = 64'sh1_0000_0000;

    // One result transaction
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [EL_W-1:0]  el;
        logic             last;
        logic             err;
    } t_sel_result;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [CMD_W-1:0]         i_cmd;
    logic [EL_W-1:0]          i_element;
    logic [CP_W-1:0]          i_component;
    logic signed [COEF_W-1:0] i_coefficient;
    logic                     i_active;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic [POS_W-1:0]         o_position;
    logic [EL_W-1:0]          o_chosen_element;
    logic                     o_last;
    logic                     o_error;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [PADDR_W-1:0]       paddr;
    logic [PDATA_W-1:0]       pwdata;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;

    independent_row_selector_core dut (.*);

    // Predictor state
    logic [EC_W-1:0]          cfg_ec;
    logic [CC_W-1:0]          cfg_cc;
    logic [THR_W-1:0]         cfg_thr;
    logic signed [COEF_W-1:0] coef_mem [MAX_ELEMENTS][MAX_COMPONENTS];
    bit                       written  [MAX_ELEMENTS][MAX_COMPONENTS];
    bit                       act_flag [MAX_ELEMENTS];
    int                       order_pos[MAX_ELEMENTS];
    bit                       tried    [MAX_ELEMENTS];
    longint                   basis    [MAX_COMPONENTS][MAX_COMPONENTS];
    longint                   basis_nrm[MAX_COMPONENTS];
    longint                   proj     [MAX_COMPONENTS];

    t_sel_result expected_sel_q[$];
    int          err_count;
    int          items_sent;
    int          idle_cycles;
    int          long_hold;
    bit          sink_eager;
    bit          gaps_off;

    // Clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // ---------------- fixed-point arithmetic ----------------
    function automatic logic [63:0] q_mag(longint a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    function automatic longint q_sat(bit neg, logic [63:0] m, bit ovf);
        bit big;
        big = ovf || m[63];
        if (!neg) return big ? Q_MAX : longint'(m);
        return big ? Q_MIN : -longint'(m);
    endfunction

    function automatic longint q_add(longint a, longint b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
        return longint'(s[63:0]);
    endfunction

    function automatic longint q_sub(longint a, longint b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
        return longint'(s[63:0]);
    endfunction

    function automatic longint q_mul(longint a, longint b);
        logic [127:0] pr;
        pr = {64'b0, q_mag(a)} * {64'b0, q_mag(b)};
        return q_sat((a < 0) != (b < 0), pr[95:32], |pr[127:96]);
    endfunction

    function automatic longint q_div(longint n, longint d);
        logic [127:0] q;
        if (d <= 0) return 0;
        q = {32'b0, q_mag(n), 32'b0} / {64'b0, d};
        return q_sat(n < 0, q[63:0], |q[127:64]);
    endfunction

    // ---------------- predictor ----------------
    function automatic void push_result(int pos, int el, bit last, bit err);
        t_sel_result r;
        r.pos  = POS_W'(pos);
        r.el   = EL_W'(el);
        r.last = last;
        r.err  = err;
        expected_sel_q.push_back(r);
    endfunction

    // Gram-Schmidt selection over the active rows
    function automatic void predict_selection();
        int     ne, nc, k, el, jr, p, i, j, tmp;
        longint cand[MAX_COMPONENTS];
        longint nrm, dot;
        ne = cfg_ec;
        nc = cfg_cc;
        if (ne == 0 || ne > MAX_ELEMENTS || nc == 0 || nc > MAX_COMPONENTS) begin
            push_result(0, 0, 1'b1, 1'b1);
            return;
        end
        for (p = 0; p < MAX_ELEMENTS; p++) begin
            order_pos[p] = p;
            tried[p]     = 1'b0;
        end
        for (jr = 0; jr < nc; jr++) begin
            forever begin
                k = ne;
                for (p = jr; p < ne; p++) begin
                    if (act_flag[order_pos[p]] && !tried[order_pos[p]]) begin
                        k = p;
                        break;
                    end
                end
                if (k == ne) begin
                    push_result(jr, 0, 1'b1, 1'b1);
                    return;
                end
                el = order_pos[k];
                tried[el] = 1'b1;
                for (i = 0; i < nc; i++) cand[i] = longint'(coef_mem[el][i]) * Q_ONE;
                // projections all taken from the unmodified row
                for (j = 0; j < jr; j++) begin
                    dot = 0;
                    for (i = 0; i < nc; i++) dot = q_add(dot, q_mul(cand[i], basis[j][i]));
                    proj[j] = q_div(dot, basis_nrm[j]);
                end
                for (j = 0; j < jr; j++)
                    for (i = 0; i < nc; i++)
                        cand[i] = q_sub(cand[i], q_mul(proj[j], basis[j][i]));
                nrm = 0;
                for (i = 0; i < nc; i++) begin
                    basis[jr][i] = cand[i];
                    nrm = q_add(nrm, q_mul(cand[i], cand[i]));
                end
                basis_nrm[jr] = nrm;
                if (nrm > longint'({31'b0, cfg_thr})) begin
                    tmp           = order_pos[jr];
                    order_pos[k]  = tmp;
                    order_pos[jr] = el;
                    break;
                end
            end
        end
        for (jr = 0; jr < nc; jr++) push_result(jr, order_pos[jr], jr + 1 == nc, 1'b0);
    endfunction

    function automatic void predict_item(t_cmd cmd, int el, int comp,
                                         logic signed [COEF_W-1:0] coef, bit a);
        case (cmd)
            CMD_WR_COEF: begin
                coef_mem[el][comp] = coef;
                written[el][comp]  = 1'b1;
            end
            CMD_WR_ACTIVE: act_flag[el] = a;
            CMD_RUN: predict_selection();
            default: ;
        endcase
    endfunction

    // ---------------- drivers ----------------
    task automatic send_item(t_cmd cmd, int el, int comp,
                             logic signed [COEF_W-1:0] coef, bit a);
        int gap;
        @(negedge i_clk);
        i_in_valid    = 1'b1;
        i_cmd         = cmd;
        i_element     = EL_W'(el);
        i_component   = CP_W'(comp);
        i_coefficient = coef;
        i_active      = a;
        forever begin
            @(posedge i_clk);
            if (o_in_ready) break;
        end
        predict_item(cmd, el, comp, coef, a);
        items_sent++;
        gap = 0;
        if (!gaps_off) begin
            if ($urandom_range(0, 99) < 4) gap = $urandom_range(20, 60);
            else if ($urandom_range(0, 99) < 40) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic write_coef(int el, int comp, int v);
        send_item(CMD_WR_COEF, el, comp, COEF_W'(v), 1'($urandom_range(0, 1)));
    endtask

    // When activating, fill any unwritten column in use, then set the flag
    task automatic set_active(int el, bit a);
        int c;
        if (a)
            for (c = 0; c < cfg_cc; c++)
                if (!written[el][c]) write_coef(el, c, $urandom_range(0, 8) - 4);
        send_item(CMD_WR_ACTIVE, el, $urandom_range(0, 15), COEF_W'($urandom), a);
    endtask

    task automatic start_run();
        send_item(CMD_RUN, $urandom_range(0, 31), $urandom_range(0, 15), COEF_W'($urandom),
                  1'($urandom_range(0, 1)));
    endtask

    // Wait until the block has drained and settled
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (expected_sel_q.size() == 0);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [PDATA_W-1:0] v);
        int el, c;
        wait_drained();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = v;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_ELEMENT_COUNT:   cfg_ec  = v[EC_W-1:0];
            REG_COMPONENT_COUNT: cfg_cc  = v[CC_W-1:0];
            REG_NORM_THRESHOLD:  cfg_thr = v[THR_W-1:0];
            default: ;
        endcase
        // active rows must have every column in use written
        if (idx == REG_COMPONENT_COUNT && cfg_cc <= MAX_COMPONENTS)
            for (el = 0; el < MAX_ELEMENTS; el++)
                if (act_flag[el])
                    for (c = 0; c < cfg_cc; c++)
                        if (!written[el][c]) write_coef(el, c, $urandom_range(0, 6) - 3);
    endtask

    task automatic report(string what, t_sel_result got, t_sel_result want);
        $display("mismatch %s: got pos %0d el %0d last %0d err %0d",
                 what, got.pos, got.el, got.last, got.err,
                 ", want pos %0d el %0d last %0d err %0d",
                 want.pos, want.el, want.last, want.err);
        err_count++;
    endtask

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        t_sel_result got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_position, o_chosen_element, o_last, o_error};
            if (expected_sel_q.size() == 0) begin
                report("unexpected transaction", got, got);
            end else begin
                want = expected_sel_q.pop_front();
                if (got.pos != want.pos)   report("position", got, want);
                if (got.el != want.el)     report("chosen_element", got, want);
                if (got.last != want.last) report("last", got, want);
                if (got.err != want.err)   report("error", got, want);
            end
        end
    end

    // Receiver: random stalls, always ready in eager phases, one long hold-off on request
    initial begin
        int stall;
        stall = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold > 0) begin
                i_out_ready = 1'b0;
                long_hold--;
            end else if (sink_eager) begin
                i_out_ready = 1'b1;
            end else if (stall > 0) begin
                i_out_ready = 1'b0;
                stall--;
            end else if ($urandom_range(0, 99) < 35) begin
                i_out_ready = 1'b0;
                stall = ($urandom_range(0, 99) < 6) ? $urandom_range(20, 80)
                                                    : $urandom_range(0, 2);
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------- tests ----------------
    task automatic test_empty_run();
        start_run();  // no active element after reset
    endtask

    task automatic test_directed_rows();
        reg_write(REG_ELEMENT_COUNT, 4);
        reg_write(REG_COMPONENT_COUNT, 2);
        write_coef(0, 0, 32767);
        write_coef(0, 1, 0);
        write_coef(1, 0, 32767);        // duplicate of row 0
        write_coef(1, 1, 0);
        write_coef(2, 0, 0);
        write_coef(2, 1, -32768);
        send_item(CMD_NOP, 31, 15, 16'sh7fff, 1'b1);
        set_active(0, 1'b1);
        set_active(1, 1'b1);
        set_active(2, 1'b1);
        start_run();                    // dependent row skipped
        set_active(2, 1'b0);
        start_run();                    // no candidate for position 1
        reg_write(REG_NORM_THRESHOLD, 64'h1_0000_0000);
        set_active(2, 1'b1);
        start_run();
        reg_write(REG_NORM_THRESHOLD, 0);
        start_run();
        reg_write(REG_COMPONENT_COUNT, 1);
        start_run();
    endtask

    task automatic test_bad_counts();
        reg_write(REG_ELEMENT_COUNT, 0);
        start_run();
        reg_write(REG_ELEMENT_COUNT, 63);
        start_run();
        reg_write(REG_ELEMENT_COUNT, 1);
        reg_write(REG_COMPONENT_COUNT, 0);
        start_run();
        reg_write(REG_COMPONENT_COUNT, 31);
        start_run();
        reg_write(REG_COMPONENT_COUNT, 1);
        start_run();
    endtask

    // Full-width run over all elements and components
    task automatic test_wide_run();
        int n, c, el;
        reg_write(REG_ELEMENT_COUNT, 32);
        reg_write(REG_COMPONENT_COUNT, 16);
        reg_write(REG_NORM_THRESHOLD, 4295);
        for (n = 0; n < 4; n++) begin
            el = $urandom_range(0, 31);
            for (c = 0; c < 16; c++) write_coef(el, c, $urandom_range(0, 65535) - 32768);
            set_active(el, 1'b1);
        end
        start_run();
    endtask

    // Hold off the receiver while runs keep coming
    task automatic test_backpressure();
        reg_write(REG_COMPONENT_COUNT, 3);
        reg_write(REG_ELEMENT_COUNT, 32);
        long_hold = 3000;               // outlasts the first run, so its results back up
        gaps_off  = 1'b1;
        start_run();
        start_run();
        start_run();
        gaps_off  = 1'b0;
        wait_drained();                 // sender pauses until all results are in
    endtask

    task automatic test_random();
        int n, ph, el, src, c, scale, ec;
        logic [PDATA_W-1:0] thr;
        for (ph = 0; items_sent < 450; ph++) begin
            sink_eager = (ph % 5 == 3);
            ec = ($urandom_range(0, 9) < 2) ? (($urandom_range(0, 1)) ? 1 : 32)
                                           : $urandom_range(2, 32);
            reg_write(REG_ELEMENT_COUNT, ec);
            reg_write(REG_COMPONENT_COUNT, ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8)
                                                                       : $urandom_range(1, 4));
            case ($urandom_range(0, 5))
                0: thr = 0;
                1: thr = 64'h1_0000_0000;
                2: thr = 4295;
                default: thr = PDATA_W'($urandom);
            endcase
            reg_write(REG_NORM_THRESHOLD, thr);
            for (n = 0; n < 4; n++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin       // load a row, sometimes a multiple of another
                        el    = $urandom_range(0, ec - 1);
                        src   = $urandom_range(0, ec - 1);
                        scale = $urandom_range(0, 4) - 2;
                        for (c = 0; c < cfg_cc; c++)
                            if ($urandom_range(0, 2) == 0 && written[src][c])
                                write_coef(el, c, scale * coef_mem[src][c]);
                            else if ($urandom_range(0, 3) == 0)
                                write_coef(el, c, $urandom_range(0, 65535) - 32768);
                            else
                                write_coef(el, c, $urandom_range(0, 10) - 5);
                        set_active(el, 1'b1);
                    end
                    4: set_active($urandom_range(0, 31), $urandom_range(0, 3) == 0);
                    5: send_item(t_cmd'($urandom_range(0, 3)), $urandom_range(0, 31),
                                 $urandom_range(0, 15), COEF_W'($urandom), 1'b0);
                    6: write_coef($urandom_range(0, 31), $urandom_range(0, 15),
                                  $urandom_range(0, 65535) - 32768);
                    default: start_run();
                endcase
            end
            start_run();
        end
        sink_eager = 1'b0;
    endtask

    initial begin
        err_count     = 0;
        items_sent    = 0;
        idle_cycles   = 0;
        long_hold     = 0;
        sink_eager    = 1'b0;
        gaps_off      = 1'b0;
        cfg_ec        = EC_RESET;
        cfg_cc        = CC_RESET;
        cfg_thr       = THR_RESET;
        foreach (act_flag[e]) act_flag[e] = 1'b0;
        foreach (written[e, c]) begin
            written[e][c]  = 1'b0;
            coef_mem[e][c] = '0;
        end
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_cmd         = CMD_NOP;
        i_element     = '0;
        i_component   = '0;
        i_coefficient = '0;
        i_active      = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_run();
        test_directed_rows();
        test_bad_counts();
        test_wide_run();
        test_backpressure();
        test_random();

        wait_drained();
        repeat (200) @(negedge i_clk);
        if (err_count == 0 && expected_sel_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
